[hw/rtl/u16u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the front end, the job queue, the byte emitter and the top level.
// No dependencies.
package u16u8_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned NB_W    = 3;   // byte count of one job, 0 to 4

    localparam logic [UNIT_W-1:0] MAX_1BYTE   = 16'h007f;
    localparam logic [UNIT_W-1:0] MAX_2BYTE   = 16'h07ff;
    localparam logic [5:0]        HIGH_PREFIX = 6'b110110;  // 0xd800 to 0xdbff
    localparam logic [5:0]        LOW_PREFIX  = 6'b110111;  // 0xdc00 to 0xdfff
    localparam logic [BYTE_W-1:0] LEAD_2      = 8'hc0;
    localparam logic [BYTE_W-1:0] LEAD_3      = 8'he0;
    localparam logic [BYTE_W-1:0] LEAD_4      = 8'hf0;
    localparam logic [BYTE_W-1:0] CONT_MARK   = 8'h80;
    localparam logic [10:0]       PLANE_BIAS  = 11'h040;
    localparam logic [COUNT_W-1:0] CAP_RESET  = 16'hffff;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SURR = 2'd1,
        ST_CAP_FULL = 2'd2,
        ST_NUL      = 2'd3
    } t_status;

    // One accepted code unit after classification: what the back end must emit.
    typedef struct packed {
        logic [3:0][BYTE_W-1:0] bytes;       // bytes[0] goes out first
        logic [NB_W-1:0]        n_bytes;
        logic                   eos;
        t_status                status;      // meaningful when eos is set
        logic [COUNT_W-1:0]     base_count;  // bytes written before this job
    } t_job;

endpackage

[hw/rtl/utf16_to_utf8_encoder.sv]
// Top level of the UTF-16 to UTF-8 encoder: front end, job queue and byte
// emitter. Depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back.
//
//  Channel   | Dir | Handshake            | Content
//  s_axis    | in  | tvalid/tready        | tdata[15:0] code_unit, tlast end_of_string
//  m_axis    | out | tvalid/tready        | tdata, tuser byte_present, tlast run_last
//  cfg       | in  | wr_en, no wait       | wr_data[15:0] output_capacity
//
// A code unit is accepted whenever the job queue has room; the byte emitter
// then sends one result per cycle while the output is not stalled, one per
// byte of each queued job (1 to 4), or one status result for a job with none.
// A held high surrogate or a non-final unit of a stopped string makes no result.
// Reset is synchronous and clears the queue, the string state and sets the
// capacity to 65535. Either side may stall; the queue absorbs the difference.
module utf16_to_utf8_encoder #(
    parameter int unsigned P_QUEUE_DEPTH = 4   // range 2 and up
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [15:0] code_unit
    input  logic        i_s_axis_tlast,    // end_of_string
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] data_byte, [8] string_done, [10:9] finish_status,
    // [26:11] byte_count, [31:27] zero
    output logic [31:0] o_m_axis_tdata,
    output logic [0:0]  o_m_axis_tuser,    // [0] byte_present
    output logic        o_m_axis_tlast     // run_last
);
    import u16u8_pkg::*;

    t_job        push_job;
    t_job        head_job;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        string_done;
    logic [1:0]  finish_status;
    logic [15:0] byte_count;

    u16u8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_code_unit   (i_s_axis_tdata),
        .i_eos         (i_s_axis_tlast),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    u16u8_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (push),
        .i_wr_data (push_job),
        .o_full    (queue_full),
        .i_rd_en   (pop),
        .o_empty   (queue_empty),
        .o_rd_data (head_job)
    );

    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_queue_empty   (queue_empty),
        .i_job           (head_job),
        .o_pop           (pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_data_byte     (data_byte),
        .o_byte_present  (byte_present),
        .o_run_last      (o_m_axis_tlast),
        .o_string_done   (string_done),
        .o_finish_status (finish_status),
        .o_byte_count    (byte_count)
    );

    assign o_m_axis_tdata = {5'b0, byte_count, finish_status, string_done, data_byte};
    assign o_m_axis_tuser = byte_present;

endmodule

[hw/rtl/u16u8_front.sv]
// Front end: accepts code units, keeps the per-string state and the capacity
// register, and turns each unit into an encoding job. Depends on u16u8_pkg.
module u16u8_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [15:0]              i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [15:0]              i_code_unit,
    input  logic                     i_eos,
    input  logic                     i_queue_full,
    output logic                     o_push,
    output u16u8_pkg::t_job          o_job
);
    import u16u8_pkg::*;

    logic [COUNT_W-1:0] r_capacity;
    logic [9:0]         r_pending_high, n_pending_high;
    logic               r_pending_valid, n_pending_valid;
    logic [COUNT_W-1:0] r_bytes_written, n_bytes_written;
    logic               r_stopped, n_stopped;
    t_status            r_stop_code, n_stop_code;

    logic               accept;
    logic               is_high, is_low;
    logic [NB_W-1:0]    need;
    logic [COUNT_W:0]   room_diff;
    logic               room_short;
    logic [10:0]        plane_hi;
    logic [3:0][BYTE_W-1:0] bytes;
    logic [NB_W-1:0]    n_bytes;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    assign is_high = (i_code_unit[15:10] == HIGH_PREFIX);
    assign is_low  = (i_code_unit[15:10] == LOW_PREFIX);

    always_comb begin
        if (i_code_unit <= MAX_1BYTE) begin
            need = NB_W'(1);
        end else if (i_code_unit <= MAX_2BYTE) begin
            need = NB_W'(2);
        end else if (is_high) begin
            need = NB_W'(4);
        end else begin
            need = NB_W'(3);
        end
    end

    // A negative difference means the string is already past capacity.
    assign room_diff  = {1'b0, r_capacity} - {1'b0, r_bytes_written};
    assign room_short = room_diff[COUNT_W] || (room_diff[COUNT_W-1:0] < COUNT_W'(need));
    assign plane_hi   = PLANE_BIAS + {1'b0, r_pending_high};

    always_comb begin
        n_pending_high  = r_pending_high;
        n_pending_valid = r_pending_valid;
        n_stopped       = r_stopped;
        n_stop_code     = r_stop_code;
        n_bytes         = '0;
        bytes           = '0;

        if (!r_stopped) begin
            if (r_pending_valid) begin
                n_pending_valid = 1'b0;
                if (is_low) begin
                    bytes[0] = LEAD_4 | {5'b0, plane_hi[10:8]};
                    bytes[1] = CONT_MARK | {2'b0, plane_hi[7:2]};
                    bytes[2] = CONT_MARK | {2'b0, plane_hi[1:0], i_code_unit[9:6]};
                    bytes[3] = CONT_MARK | {2'b0, i_code_unit[5:0]};
                    n_bytes  = NB_W'(4);
                end else begin
                    n_stopped   = 1'b1;
                    n_stop_code = ST_BAD_SURR;
                end
            end else if (i_code_unit == '0) begin
                n_stopped   = 1'b1;
                n_stop_code = ST_NUL;
            end else if (room_short) begin
                n_stopped   = 1'b1;
                n_stop_code = ST_CAP_FULL;
            end else if (i_code_unit <= MAX_1BYTE) begin
                bytes[0] = i_code_unit[7:0];
                n_bytes  = NB_W'(1);
            end else if (i_code_unit <= MAX_2BYTE) begin
                bytes[0] = LEAD_2 | {3'b0, i_code_unit[10:6]};
                bytes[1] = CONT_MARK | {2'b0, i_code_unit[5:0]};
                n_bytes  = NB_W'(2);
            end else if (is_high) begin
                if (i_eos) begin
                    n_stopped   = 1'b1;
                    n_stop_code = ST_BAD_SURR;
                end else begin
                    n_pending_high  = i_code_unit[9:0];
                    n_pending_valid = 1'b1;
                end
            end else begin
                bytes[0] = LEAD_3 | {4'b0, i_code_unit[15:12]};
                bytes[1] = CONT_MARK | {2'b0, i_code_unit[11:6]};
                bytes[2] = CONT_MARK | {2'b0, i_code_unit[5:0]};
                n_bytes  = NB_W'(3);
            end
        end

        n_bytes_written = r_bytes_written + COUNT_W'(n_bytes);

        o_job.bytes      = bytes;
        o_job.n_bytes    = n_bytes;
        o_job.eos        = i_eos;
        o_job.status     = n_stopped ? n_stop_code : ST_OK;
        o_job.base_count = r_bytes_written;

        // The end of a string returns the string state to its reset value.
        if (i_eos) begin
            n_pending_high  = '0;
            n_pending_valid = 1'b0;
            n_bytes_written = '0;
            n_stopped       = 1'b0;
            n_stop_code     = ST_OK;
        end
    end

    assign o_push = accept && (i_eos || (n_bytes != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity      <= CAP_RESET;
            r_pending_high  <= '0;
            r_pending_valid <= 1'b0;
            r_bytes_written <= '0;
            r_stopped       <= 1'b0;
            r_stop_code     <= ST_OK;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pending_high  <= n_pending_high;
                r_pending_valid <= n_pending_valid;
                r_bytes_written <= n_bytes_written;
                r_stopped       <= n_stopped;
                r_stop_code     <= n_stop_code;
            end
        end
    end

`ifndef ASSERT_OFF
    a_eos_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eos |=> (r_bytes_written == '0) && !r_stopped && !r_pending_valid)
        else $error("string state not cleared after end of string");

    a_pending_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending_valid && r_stopped))
        else $error("held high surrogate in a stopped string");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_queue_full)
        else $error("job pushed into a full queue");
`endif

endmodule

[hw/rtl/u16u8_fifo.sv]
// Short job queue between the front end and the byte emitter.
// Register-based, first in first out. Depends on u16u8_pkg.
module u16u8_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  u16u8_pkg::t_job i_wr_data,
    output logic            o_full,
    input  logic            i_rd_en,
    output logic            o_empty,
    output u16u8_pkg::t_job o_rd_data
);
    import u16u8_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd_en && !i_wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> !o_empty)
        else $error("read from an empty queue");

    a_ptrs_meet_at_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step with count");
`endif

endmodule

[hw/rtl/u16u8_back.sv]
// Byte emitter: walks through each queued job and drives one result per
// cycle into the output register while the output is not stalled. Depends on u16u8_pkg.
module u16u8_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_queue_empty,
    input  u16u8_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_present,
    output logic            o_run_last,
    output logic            o_string_done,
    output logic [1:0]      o_finish_status,
    output logic [15:0]     o_byte_count
);
    import u16u8_pkg::*;

    logic               r_valid;
    logic [1:0]         r_idx;
    logic [BYTE_W-1:0]  r_data_byte;
    logic               r_byte_present;
    logic               r_run_last;
    logic               r_string_done;
    t_status            r_finish_status;
    logic [COUNT_W-1:0] r_byte_count;

    logic               load;
    logic               status_only;
    logic               last_of_job;
    logic [BYTE_W-1:0]  n_data_byte;
    logic [COUNT_W-1:0] n_byte_count;

    assign load        = !i_queue_empty && (!r_valid || i_ready);
    assign status_only = (i_job.n_bytes == '0);
    assign last_of_job = status_only || ((NB_W'(r_idx) + NB_W'(1)) == i_job.n_bytes);
    assign o_pop       = load && last_of_job;

    always_comb begin
        if (status_only) begin
            n_data_byte  = '0;
            n_byte_count = i_job.base_count;
        end else begin
            n_data_byte  = i_job.bytes[r_idx];
            n_byte_count = i_job.base_count + COUNT_W'(r_idx) + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data_byte     <= n_data_byte;
            r_byte_present  <= !status_only;
            r_run_last      <= last_of_job;
            r_string_done   <= last_of_job && i_job.eos;
            r_finish_status <= (last_of_job && i_job.eos) ? i_job.status : ST_OK;
            r_byte_count    <= n_byte_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_of_job ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_data_byte;
    assign o_byte_present  = r_byte_present;
    assign o_run_last      = r_run_last;
    assign o_string_done   = r_string_done;
    assign o_finish_status = r_finish_status;
    assign o_byte_count    = r_byte_count;

`ifndef ASSERT_OFF
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_queue_empty && !status_only) |-> (NB_W'(r_idx) < i_job.n_bytes))
        else $error("byte index past the end of the job");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_string_done) |-> r_run_last)
        else $error("string end not on the last result of its unit");

    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_byte_present) |-> (r_string_done && r_data_byte == '0))
        else $error("status-only result without string end");
`endif

endmodule
